@@ rtl/core/imu_roll_complementary_filter_defines.svh @@
// Assertion macros shared by the roll filter RTL.
`ifndef IMU_ROLL_COMPLEMENTARY_FILTER_DEFINES_SVH
`define IMU_ROLL_COMPLEMENTARY_FILTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define IRC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define IRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ rtl/core/irc_pkg.sv @@
// Shared constants, types and the arctangent table of the roll filter.
`timescale 1ns / 1ps
`default_nettype none

package irc_pkg;

    // Sample fields and configuration widths
    localparam int SAMPLE_W   = 16;
    localparam int ALPHA_W    = 16;
    localparam int SCALE_W    = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd58982;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd327862;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_ALPHA     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_STEP_SCALE = 1'b1;

    // CORDIC
    localparam int CORDIC_STEPS   = 16;
    localparam int ATAN_LEN       = 24;
    localparam int CORDIC_ITERS   = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int ITER_W         = $clog2(ATAN_LEN);
    localparam int ATAN_W         = 21;
    localparam int CW             = 27;   // x/y datapath, inputs scaled by 256
    localparam int ZW             = 26;   // angle accumulator, 1/32768 degree
    localparam int HALF_TURN_FINE = 180 * 32768;
    localparam int ACCEL_ROLL_LIMIT = 23040;

    // Blend datapath
    localparam int MUL_W    = 25;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int INC_W    = 41;         // gyro_x * scale
    localparam int INC_LO_W = 24;
    localparam int MIX_W    = 60;
    localparam int FRAC_SH  = 40;
    localparam int ANG_SH   = 24;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    typedef enum logic [2:0] {
        OP_GYRO_INC,
        OP_ROLL,
        OP_ACCEL,
        OP_INC_LO,
        OP_INC_HI
    } blend_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_BLEND,
        ST_HOLD
    } top_state_t;

    // atan(2^-i) in 1/32768 degree, rounded to nearest
    function automatic logic [ATAN_W-1:0] atan_fine(input logic [ITER_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 21'd1474560;
            5'd1:    v = 21'd870484;
            5'd2:    v = 21'd459940;
            5'd3:    v = 21'd233473;
            5'd4:    v = 21'd117189;
            5'd5:    v = 21'd58652;
            5'd6:    v = 21'd29333;
            5'd7:    v = 21'd14667;
            5'd8:    v = 21'd7334;
            5'd9:    v = 21'd3667;
            5'd10:   v = 21'd1833;
            5'd11:   v = 21'd917;
            5'd12:   v = 21'd458;
            5'd13:   v = 21'd229;
            5'd14:   v = 21'd115;
            5'd15:   v = 21'd57;
            5'd16:   v = 21'd29;
            5'd17:   v = 21'd14;
            5'd18:   v = 21'd7;
            5'd19:   v = 21'd4;
            5'd20:   v = 21'd2;
            5'd21:   v = 21'd1;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/irc_if.sv @@
// Sample and result channel interfaces of the roll filter.
`timescale 1ns / 1ps
`default_nettype none

interface irc_sample_if;
    import irc_pkg::*;

    logic    valid;
    logic    ready;
    sample_t accel_y;
    sample_t accel_z;
    sample_t gyro_x;

    modport source (output valid, output accel_y, output accel_z, output gyro_x,
                    input ready);
    modport sink   (input valid, input accel_y, input accel_z, input gyro_x,
                    output ready);
endinterface

interface irc_result_if;
    import irc_pkg::*;

    logic    valid;
    logic    ready;
    sample_t roll_out;
    sample_t accel_roll_out;

    modport source (output valid, output roll_out, output accel_roll_out, input ready);
    modport sink   (input valid, input roll_out, input accel_roll_out, output ready);
endinterface

`default_nettype wire

@@ rtl/core/irc_cordic.sv @@
// Iterative vectoring CORDIC: accelerometer roll atan2(ay, -az).
`timescale 1ns / 1ps
`default_nettype none

module irc_cordic (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire irc_pkg::sample_t       accel_y,
    input  wire irc_pkg::sample_t       accel_z,
    output irc_pkg::unit_status_t       status,
    output irc_pkg::sample_t            angle
);
    import irc_pkg::*;

    logic signed [CW-1:0]  x_reg, x_next;
    logic signed [CW-1:0]  y_reg, y_next;
    logic signed [ZW-1:0]  z_reg, z_next;
    logic [ITER_W-1:0]     iter_reg, iter_next;
    logic                  busy_reg, busy_next;
    logic                  fin_reg, fin_next;
    logic                  done_reg, done_next;
    logic                  zero_reg, zero_next;
    sample_t               angle_reg, angle_next;

    logic signed [CW-1:0]  x_init, y_init, xs, ys;
    logic signed [ZW-1:0]  step, z_round;

    // Rotation step; one iteration per cycle, x and y shifted by the iteration index
    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        iter_next  = iter_reg;
        busy_next  = busy_reg;
        fin_next   = 1'b0;
        done_next  = 1'b0;
        zero_next  = zero_reg;
        angle_next = angle_reg;

        x_init  = -(CW'(accel_z) <<< 8);
        y_init  = CW'(accel_y) <<< 8;
        xs      = x_reg >>> iter_reg;
        ys      = y_reg >>> iter_reg;
        step    = $signed(ZW'(atan_fine(iter_reg)));
        z_round = (z_reg + ZW'(128)) >>> 8;

        if (start)
        begin
            zero_next = (accel_y == '0) && (accel_z == '0);
            iter_next = '0;
            busy_next = 1'b1;
            // Left half plane: flip the vector, start from +-180 degrees
            if (x_init < 0)
            begin
                x_next = -x_init;
                y_next = -y_init;
                z_next = (y_init >= 0) ? ZW'(HALF_TURN_FINE) : -ZW'(HALF_TURN_FINE);
            end
            else
            begin
                x_next = x_init;
                y_next = y_init;
                z_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (!y_reg[CW-1])
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + step;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - step;
            end
            iter_next = iter_reg + ITER_W'(1);
            if (iter_reg == ITER_W'(CORDIC_ITERS - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end

        // Round to 1/128 degree and clamp; a zero vector gives zero
        if (fin_reg)
        begin
            done_next = 1'b1;
            if (zero_reg)
                angle_next = '0;
            else if (z_round > ZW'(ACCEL_ROLL_LIMIT))
                angle_next = SAMPLE_W'(ACCEL_ROLL_LIMIT);
            else if (z_round < -ZW'(ACCEL_ROLL_LIMIT))
                angle_next = -SAMPLE_W'(ACCEL_ROLL_LIMIT);
            else
                angle_next = z_round[SAMPLE_W-1:0];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        iter_reg  <= iter_next;
        zero_reg  <= zero_next;
        angle_reg <= angle_next;
    end

    assign status.busy = busy_reg | fin_reg;
    assign status.done = done_reg;
    assign angle       = angle_reg;

endmodule

`default_nettype wire

@@ rtl/core/irc_blend.sv @@
// Complementary blend on one shared 25x25 multiplier, five products in turn.
`timescale 1ns / 1ps
`default_nettype none

module irc_blend (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [irc_pkg::ALPHA_W-1:0]     alpha,
    input  wire logic [irc_pkg::SCALE_W-1:0]     scale,
    input  wire irc_pkg::sample_t                roll,
    input  wire irc_pkg::sample_t                accel_roll,
    input  wire irc_pkg::sample_t                gyro,
    output irc_pkg::unit_status_t                status,
    output irc_pkg::sample_t                     roll_new
);
    import irc_pkg::*;

    blend_op_t                op_reg, op_next;
    logic                     phase_reg, phase_next;   // 0: multiply, 1: accumulate
    logic                     busy_reg, busy_next;
    logic                     fin_reg, fin_next;
    logic                     done_reg, done_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [INC_W-1:0]  inc_reg, inc_next;
    logic signed [MIX_W-1:0]  mix_reg, mix_next;
    sample_t                  res_reg, res_next;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [MIX_W-1:0]  mix_shr;

    // Operand select for the shared multiplier
    always_comb
    begin
        case (op_reg)
            OP_GYRO_INC:
            begin
                mul_a = MUL_W'(gyro);
                mul_b = $signed({1'b0, scale});
            end
            OP_ROLL:
            begin
                mul_a = $signed(MUL_W'(alpha));
                mul_b = MUL_W'(roll);
            end
            OP_ACCEL:
            begin
                mul_a = $signed(MUL_W'({1'b1, {ALPHA_W{1'b0}}} - {1'b0, alpha}));
                mul_b = MUL_W'(accel_roll);
            end
            OP_INC_LO:
            begin
                mul_a = $signed(MUL_W'(alpha));
                mul_b = $signed(MUL_W'(inc_reg[INC_LO_W-1:0]));
            end
            OP_INC_HI:
            begin
                // upper part of the increment keeps its sign
                mul_a = $signed(MUL_W'(alpha));
                mul_b = MUL_W'($signed(inc_reg[INC_W-1:INC_LO_W]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer: multiply, then accumulate, for each product
    always_comb
    begin
        op_next    = op_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        fin_next   = 1'b0;
        done_next  = 1'b0;
        prod_next  = prod_reg;
        inc_next   = inc_reg;
        mix_next   = mix_reg;
        res_next   = res_reg;
        mix_shr    = mix_reg >>> FRAC_SH;

        if (start)
        begin
            busy_next  = 1'b1;
            op_next    = OP_GYRO_INC;
            phase_next = 1'b0;
            // Rounding half preloaded
            mix_next   = MIX_W'(1) <<< (FRAC_SH - 1);
        end
        else if (busy_reg && !phase_reg)
        begin
            prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);
            phase_next = 1'b1;
        end
        else if (busy_reg)
        begin
            phase_next = 1'b0;
            case (op_reg)
                OP_GYRO_INC:
                begin
                    inc_next = prod_reg[INC_W-1:0];
                    op_next  = OP_ROLL;
                end
                OP_ROLL:
                begin
                    mix_next = mix_reg + (MIX_W'(prod_reg) <<< ANG_SH);
                    op_next  = OP_ACCEL;
                end
                OP_ACCEL:
                begin
                    mix_next = mix_reg + (MIX_W'(prod_reg) <<< ANG_SH);
                    op_next  = OP_INC_LO;
                end
                OP_INC_LO:
                begin
                    mix_next = mix_reg + MIX_W'(prod_reg);
                    op_next  = OP_INC_HI;
                end
                OP_INC_HI:
                begin
                    mix_next  = mix_reg + (MIX_W'(prod_reg) <<< ANG_SH);
                    busy_next = 1'b0;
                    fin_next  = 1'b1;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end

        // Scale down and saturate to the field range
        if (fin_reg)
        begin
            done_next = 1'b1;
            if (mix_shr > MIX_W'(32767))
                res_next = 16'sh7FFF;
            else if (mix_shr < -MIX_W'(32768))
                res_next = 16'sh8000;
            else
                res_next = mix_shr[SAMPLE_W-1:0];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= OP_GYRO_INC;
            phase_reg <= 1'b0;
            busy_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            op_reg    <= op_next;
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            fin_reg   <= fin_next;
            done_reg  <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        inc_reg  <= inc_next;
        mix_reg  <= mix_next;
        res_reg  <= res_next;
    end

    assign status.busy = busy_reg | fin_reg;
    assign status.done = done_reg;
    assign roll_new    = res_reg;

endmodule

`default_nettype wire

@@ rtl/core/imu_roll_complementary_filter.sv @@
// Roll complementary filter top level: sequencer, config registers, output word.
//
// Usage:
//   sample (sink): one word per IMU sample, accel_y, accel_z, gyro_x as signed
//   16-bit counts, taken when valid and ready are both high.
//   result (source): one word per sample, roll_out (filtered roll) and
//   accel_roll_out (accelerometer roll), both signed 1/128 degree.
//   cfg_we/cfg_index/cfg_data write blend_alpha (index 0, Q0.16) and
//   gyro_step_scale (index 1, Q0.24); write only while the block is idle.
// Timing:
//   The CORDIC runs one iteration per cycle (16 iterations), and the blend
//   uses one shared multiplier for five products, each multiplied and then
//   accumulated. Every sample goes through the CORDIC; the first one after
//   reset just loads the filter, later ones then go through the blend.
//   sample.ready is high only while no sample is in work.
// Reset: config registers return to their defaults, the filtered roll is
//   cleared and the next sample loads it from the accelerometer roll.
// Stall: a finished word waits in the output register; the block takes the
//   next sample meanwhile and holds its result until the register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "imu_roll_complementary_filter_defines.svh"

module imu_roll_complementary_filter (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [irc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [irc_pkg::CFG_DATA_W-1:0]    cfg_data,
    irc_sample_if.sink                             sample,
    irc_result_if.source                           result
);
    import irc_pkg::*;

    top_state_t           state_reg, state_next;
    logic [ALPHA_W-1:0]   alpha_reg, alpha_next;
    logic [SCALE_W-1:0]   scale_reg, scale_next;
    sample_t              roll_angle_reg, roll_angle_next;
    logic                 started_reg, started_next;
    sample_t              gyro_reg, gyro_next;
    sample_t              accel_roll_reg, accel_roll_next;
    logic                 res_valid_reg, res_valid_next;
    sample_t              res_roll_reg, res_roll_next;
    sample_t              res_accel_reg, res_accel_next;

    logic                 accept;
    logic                 blend_start;
    logic                 out_load;
    unit_status_t         cordic_stat, blend_stat;
    sample_t              cordic_angle, blend_roll;

    assign accept = sample.valid && sample.ready;

    // Accelerometer roll
    irc_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .accel_y (sample.accel_y),
        .accel_z (sample.accel_z),
        .status  (cordic_stat),
        .angle   (cordic_angle)
    );

    // Gyro/accel blend
    irc_blend u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (blend_start),
        .alpha      (alpha_reg),
        .scale      (scale_reg),
        .roll       (roll_angle_reg),
        .accel_roll (accel_roll_reg),
        .gyro       (gyro_reg),
        .status     (blend_stat),
        .roll_new   (blend_roll)
    );

    // Next state, sequencing and register updates
    always_comb
    begin
        state_next      = state_reg;
        alpha_next      = alpha_reg;
        scale_next      = scale_reg;
        roll_angle_next = roll_angle_reg;
        started_next    = started_reg;
        gyro_next       = gyro_reg;
        accel_roll_next = accel_roll_reg;
        res_roll_next   = res_roll_reg;
        res_accel_next  = res_accel_reg;
        blend_start     = 1'b0;
        out_load        = 1'b0;
        sample.ready    = (state_reg == ST_IDLE);

        // Config write
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BLEND_ALPHA:     alpha_next = cfg_data[ALPHA_W-1:0];
                REG_GYRO_STEP_SCALE: scale_next = cfg_data[SCALE_W-1:0];
                default:             ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    gyro_next  = sample.gyro_x;
                    state_next = ST_ANGLE;
                end
            end
            ST_ANGLE:
            begin
                if (cordic_stat.done)
                begin
                    accel_roll_next = cordic_angle;
                    if (started_reg)
                    begin
                        blend_start = 1'b1;
                        state_next  = ST_BLEND;
                    end
                    else
                    begin
                        // First sample: load the filter directly
                        roll_angle_next = cordic_angle;
                        started_next    = 1'b1;
                        state_next      = ST_HOLD;
                    end
                end
            end
            ST_BLEND:
            begin
                if (blend_stat.done)
                begin
                    roll_angle_next = blend_roll;
                    state_next      = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    out_load       = 1'b1;
                    res_roll_next  = roll_angle_reg;
                    res_accel_next = accel_roll_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Output word register
        if (out_load)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            alpha_reg      <= ALPHA_RESET;
            scale_reg      <= SCALE_RESET;
            roll_angle_reg <= '0;
            started_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            alpha_reg      <= alpha_next;
            scale_reg      <= scale_next;
            roll_angle_reg <= roll_angle_next;
            started_reg    <= started_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        gyro_reg       <= gyro_next;
        accel_roll_reg <= accel_roll_next;
        res_roll_reg   <= res_roll_next;
        res_accel_reg  <= res_accel_next;
    end

    assign result.valid          = res_valid_reg;
    assign result.roll_out       = res_roll_reg;
    assign result.accel_roll_out = res_accel_reg;

    // Checks
    `IRC_ASSERT_IMPL(a_no_overwrite, clk, rst_n, out_load, !res_valid_reg || result.ready)
    `IRC_ASSERT_IMPL(a_blend_needs_start, clk, rst_n, blend_start, started_reg)
    `IRC_ASSERT_IMPL(a_accel_range, clk, rst_n, cordic_stat.done, (cordic_angle <= SAMPLE_W'(ACCEL_ROLL_LIMIT)) && (cordic_angle >= -SAMPLE_W'(ACCEL_ROLL_LIMIT)))
    `IRC_ASSERT_NEXT(a_started_after_load, clk, rst_n, out_load, started_reg)
    `IRC_ASSERT_IMPL(a_cordic_idle_on_accept, clk, rst_n, accept, !cordic_stat.busy && !blend_stat.busy)

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking testbench for the IMU roll complementary filter.
`timescale 1ns / 1ps

module tb_top;
    import irc_pkg::*;

    typedef struct packed {
        sample_t ay;
        sample_t az;
        sample_t gx;
    } imu_word_t;

    typedef struct packed {
        sample_t roll;
        sample_t tilt;
    } roll_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    irc_sample_if sample ();
    irc_result_if result ();

    imu_roll_complementary_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .result    (result)
    );

    // Pending sample words and expected result words
    imu_word_t  imu_q[$];
    roll_word_t roll_due_q[$];

    int send_gap_pct;
    int recv_stall_pct;
    int err_count;

    // Filter state as the block should hold it
    logic [ALPHA_W-1:0] alpha_reg;
    logic [SCALE_W-1:0] scale_reg;
    longint             filt_roll;
    bit                 filt_loaded;

    // atan(2^-i) in 1/32768 degree
    longint atan_steps [0:23] = '{
        1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
        7334, 3667, 1833, 917, 458, 229, 115, 57,
        29, 14, 7, 4, 2, 1, 0, 0
    };

    // Accelerometer roll atan2(ay, -az) by vectoring CORDIC, 1/128 degree
    function automatic longint tilt_angle(input sample_t ay, input sample_t az);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        int     n;
        int     i;
        x = -longint'(az) * 256;
        y = longint'(ay) * 256;
        z = 0;
        n = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
        if (ay == 0 && az == 0)
            return 0;
        // left half plane: rotate by half a turn first
        if (x < 0)
        begin
            z = (y >= 0) ? longint'(HALF_TURN_FINE) : -longint'(HALF_TURN_FINE);
            x = -x;
            y = -y;
        end
        for (i = 0; i < n; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_steps[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_steps[i];
            end
        end
        z = (z + 128) >>> 8;
        if (z > ACCEL_ROLL_LIMIT)
            z = ACCEL_ROLL_LIMIT;
        if (z < -ACCEL_ROLL_LIMIT)
            z = -ACCEL_ROLL_LIMIT;
        return z;
    endfunction

    // Step the filter on one accepted word and queue the expected result
    task automatic advance_filter(input sample_t ay, input sample_t az, input sample_t gx);
        longint     tilt;
        longint     a;
        longint     sum;
        longint     mix;
        longint     r;
        roll_word_t w;
        tilt = tilt_angle(ay, az);
        if (!filt_loaded)
        begin
            filt_roll   = tilt;
            filt_loaded = 1'b1;
        end
        else
        begin
            a   = longint'(alpha_reg);
            sum = filt_roll * 64'sd16777216 + longint'(gx) * longint'(scale_reg);
            mix = a * sum + (64'sd65536 - a) * tilt * 64'sd16777216;
            r   = (mix + (64'sd1 <<< 39)) >>> 40;
            if (r > 32767)
                r = 32767;
            if (r < -32768)
                r = -32768;
            filt_roll = r;
        end
        w.roll = sample_t'(filt_roll);
        w.tilt = sample_t'(tilt);
        roll_due_q.push_back(w);
    endtask

    task automatic report(input string what, input int got, input int want);
        if (err_count < 200)
            $display("tb_top: %s mismatch, got %0d, expected %0d", what, got, want);
        err_count++;
    endtask

    // Clock, reset and time-zero values of every input
    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        sample.valid = 1'b0;
        sample.accel_y = '0;
        sample.accel_z = '0;
        sample.gyro_x  = '0;
        result.ready = 1'b0;
        fork
            forever #2 clk = ~clk;
            begin
                repeat (7) @(posedge clk);
                rst_n <= 1'b1;
            end
        join_none
    end

    // Sample driver
    always @(posedge clk or negedge rst_n)
    begin : drive
        imu_word_t nxt;
        if (!rst_n)
        begin
            sample.valid   <= 1'b0;
            sample.accel_y <= '0;
            sample.accel_z <= '0;
            sample.gyro_x  <= '0;
        end
        else if (!sample.valid || sample.ready)
        begin
            if (sample.valid)
                advance_filter(sample.accel_y, sample.accel_z, sample.gyro_x);
            if (imu_q.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                nxt = imu_q.pop_front();
                sample.valid   <= 1'b1;
                sample.accel_y <= nxt.ay;
                sample.accel_z <= nxt.az;
                sample.gyro_x  <= nxt.gx;
            end
            else
            begin
                sample.valid <= 1'b0;
            end
        end
    end

    // Result ready with random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
            result.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor
    always @(posedge clk)
    begin : watch
        roll_word_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (roll_due_q.size() == 0)
            begin
                report("unexpected word", result.roll_out, 0);
            end
            else
            begin
                want = roll_due_q.pop_front();
                if (result.roll_out !== want.roll)
                    report("roll_out", result.roll_out, want.roll);
                if (result.accel_roll_out !== want.tilt)
                    report("accel_roll_out", result.accel_roll_out, want.tilt);
            end
        end
    end

    task automatic push_word(input int ay, input int az, input int gx);
        imu_word_t w;
        w.ay = sample_t'(ay);
        w.az = sample_t'(az);
        w.gx = sample_t'(gx);
        imu_q.push_back(w);
    endtask

    function automatic sample_t corner_value();
        case ($urandom_range(4))
            0:       return sample_t'(-32768);
            1:       return sample_t'(-1);
            2:       return sample_t'(0);
            3:       return sample_t'(1);
            default: return sample_t'(32767);
        endcase
    endfunction

    // Plausible tilts with modest rates, plus raw noise and corners
    task automatic push_random(input int count);
        imu_word_t w;
        int        k;
        int        mode;
        for (k = 0; k < count; k++)
        begin
            mode = $urandom_range(99);
            if (mode < 45)
            begin
                w.ay = sample_t'(int'($urandom_range(32767)) - 16384);
                w.az = sample_t'(int'($urandom_range(32767)) - 16384);
                w.gx = sample_t'(int'($urandom_range(4000)) - 2000);
            end
            else if (mode < 85)
            begin
                w.ay = sample_t'($urandom);
                w.az = sample_t'($urandom);
                w.gx = sample_t'($urandom);
            end
            else
            begin
                w.ay = corner_value();
                w.az = corner_value();
                w.gx = corner_value();
            end
            imu_q.push_back(w);
        end
    endtask

    // Wait until every word has gone through and the pipeline is empty
    task automatic settle();
        do
            @(negedge clk);
        while (imu_q.size() != 0 || sample.valid || roll_due_q.size() != 0);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        if (idx == REG_BLEND_ALPHA)
            alpha_reg = ALPHA_W'(val);
        else
            scale_reg = SCALE_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stimulus sequence
    initial
    begin
        int seg;
        err_count      = 0;
        send_gap_pct   = 21;
        recv_stall_pct = 82;
        alpha_reg      = ALPHA_RESET;
        scale_reg      = SCALE_RESET;
        filt_roll      = 0;
        filt_loaded    = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);

        // default registers; first word loads the filter
        push_word(12000, -14000, 0);
        push_word(0, 0, 0);              // zero vector
        push_word(32767, 0, 32767);      // +90 deg
        push_word(-32768, 0, -32768);    // -90 deg
        push_word(0, -32768, 0);         // level
        push_word(0, 32767, 100);        // upside down, clamps high
        push_word(-1, 32767, -100);      // just past -180, clamps low
        push_word(32767, 32767, 32767);
        push_word(-32768, -32768, -32768);
        push_word(-32768, 32767, 1);
        push_word(32767, -32768, -1);
        push_word(1, -1, 0);
        push_word(-1, -1, 0);

        for (seg = 0; seg < 6; seg++)
        begin
            settle();
            if (seg == 2)
            begin
                send_gap_pct   = 82;
                recv_stall_pct = 21;
            end
            if (seg == 4)
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            case (seg)
                1:
                begin
                    // full gyro trust and largest step: roll saturates
                    write_reg(REG_BLEND_ALPHA, 65535);
                    write_reg(REG_GYRO_STEP_SCALE, 24'hFFFFFF);
                    @(negedge clk);
                    repeat (4) push_word(0, -16384, 32767);
                    repeat (4) push_word(0, -16384, -32768);
                end
                2:
                begin
                    // accelerometer only
                    write_reg(REG_BLEND_ALPHA, 0);
                    write_reg(REG_GYRO_STEP_SCALE, 0);
                    @(negedge clk);
                    push_word(20000, 5000, 32767);
                    push_word(-20000, 5000, -32768);
                end
                3, 4:
                begin
                    write_reg(REG_BLEND_ALPHA, $urandom_range(65535));
                    write_reg(REG_GYRO_STEP_SCALE, $urandom_range(24'hFFFFFF));
                end
                5:
                begin
                    write_reg(REG_BLEND_ALPHA, ALPHA_RESET);
                    write_reg(REG_GYRO_STEP_SCALE, SCALE_RESET);
                end
                default:
                begin
                end
            endcase
            @(negedge clk);
            push_random(340);
        end

        settle();
        repeat (64) @(posedge clk);
        if (err_count == 0 && roll_due_q.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4ms;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/irc_pkg.sv
rtl/core/irc_if.sv
rtl/core/irc_cordic.sv
rtl/core/irc_blend.sv
rtl/core/imu_roll_complementary_filter.sv
bench/tb_top.sv
